### rtl/pidci_pkg.sv
// ----------------------------------------------------------------------------
// pidci_pkg
// shared widths, register indexes and payload types of the pid step block
// ----------------------------------------------------------------------------
package pidci_pkg;

    // fixed point format of samples, gains, limit and drive
    localparam int FRAC_BITS = 16;

    localparam int SAMPLE_W  = 32;
    localparam int GAIN_W    = 31;
    localparam int DT_W      = 20;
    localparam int CFG_IDX_W = 2;

    // error and error difference
    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int ERR_MAG_W = SAMPLE_W;
    localparam int DERR_W    = SAMPLE_W + 2;
    localparam int DMAG_W    = DERR_W - 1;

    // integral keeps twice the fraction bits
    localparam int INT_W     = 32 + FRAC_BITS;

    // shared multiplier and its accumulator
    localparam int MUL_W     = 32;
    localparam int MUL2_W    = 2 * MUL_W;
    localparam int ACC_W     = 3 * MUL_W;
    localparam int PD_W      = GAIN_W + DMAG_W;

    // term magnitudes
    localparam int TP_W      = GAIN_W + ERR_MAG_W - FRAC_BITS;
    localparam int TI_W      = 62 - FRAC_BITS;
    localparam int TD_W      = 62;
    localparam int INC_W     = 33 + FRAC_BITS;
    localparam int CAND_W    = INC_W + 2;
    localparam int SUM_W     = 64;

    // divider: dividend width covers both divisions, a few quotient bits per cycle
    localparam int DIV_RADIX = 4;
    localparam int DVD_TD_W  = PD_W + DT_W - FRAC_BITS;
    localparam int DVD_INC_W = ERR_MAG_W + DT_W + FRAC_BITS;
    localparam int DVD_RAW_W = (DVD_TD_W > DVD_INC_W) ? DVD_TD_W : DVD_INC_W;
    localparam int DVD_W     = ((DVD_RAW_W + DIV_RADIX - 1) / DIV_RADIX) * DIV_RADIX;
    localparam int DIV_STEPS = DVD_W / DIV_RADIX;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [DT_W-1:0] US_PER_S = DT_W'(1000000);
    localparam logic [TD_W-1:0] TERM_CAP = {1'b1, {(TD_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]          t_gain;
    typedef logic [DT_W-1:0]            t_dt;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

endpackage

### rtl/pidci_in_if.sv
// ----------------------------------------------------------------------------
// pidci_in_if
// sample channel: one word per controller step
// ----------------------------------------------------------------------------
interface pidci_in_if;
    import pidci_pkg::*;

    logic    valid;
    logic    ready;
    t_sample setpoint;
    t_sample measured;
    t_dt     elapsed_us;
    logic    integrate_enable;
    t_sample thrust_bound;

    modport source (
        output valid,
        output setpoint,
        output measured,
        output elapsed_us,
        output integrate_enable,
        output thrust_bound,
        input  ready
    );

    modport sink (
        input  valid,
        input  setpoint,
        input  measured,
        input  elapsed_us,
        input  integrate_enable,
        input  thrust_bound,
        output ready
    );

endinterface

### rtl/pidci_out_if.sv
// ----------------------------------------------------------------------------
// pidci_out_if
// result channel: saturated drive and the integral update flag
// ----------------------------------------------------------------------------
interface pidci_out_if;
    import pidci_pkg::*;

    logic    valid;
    logic    ready;
    t_sample drive;
    logic    integral_taken;

    modport source (
        output valid,
        output drive,
        output integral_taken,
        input  ready
    );

    modport sink (
        input  valid,
        input  drive,
        input  integral_taken,
        output ready
    );

endinterface

### rtl/pidci_cfg_if.sv
// ----------------------------------------------------------------------------
// pidci_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface pidci_cfg_if;
    import pidci_pkg::*;

    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_gain    data;

    modport source (
        output valid,
        output index,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  index,
        input  data,
        output ready
    );

endinterface

### rtl/pid_step_conditional_integral.sv
// ----------------------------------------------------------------------------
// pid_step_conditional_integral
// one fixed point pid step per sample word, with conditional integration
//
// i_in takes one sample word (setpoint, measured, elapsed_us, integrate_enable,
// thrust_bound); o_out returns one word (drive, integral_taken) for each.
// i_cfg writes gain_p, gain_i, gain_d and integral_limit by index; it is always ready.
// the user must write it only while no step is in flight; the block does not enforce it.
// a step runs on one shared 32x32 multiplier (states MLO, MHI and MACC for each of
// five products) and one divider that retires four quotient bits a cycle (two
// divisions, only one when elapsed_us is zero). i_in.ready is high only between
// steps. the result sits in an output register, so the next word is taken while
// it waits; if o_out is still stalled when the next step ends, that step holds
// its result until the register frees up.
// reset clears the control registers, gains, limit, previous error and integral.
// ----------------------------------------------------------------------------
module pid_step_conditional_integral (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pidci_in_if.sink    i_in,
    pidci_out_if.source o_out,
    pidci_cfg_if.sink   i_cfg
);
    import pidci_pkg::*;

    localparam int DRV_W = SAMPLE_W + 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_DIFF  = 4'd2;
    localparam logic [3:0] ST_MLO   = 4'd3;
    localparam logic [3:0] ST_MHI   = 4'd4;
    localparam logic [3:0] ST_MACC  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_SUM   = 4'd7;
    localparam logic [3:0] ST_CLAMP = 4'd8;
    localparam logic [3:0] ST_CAND  = 4'd9;
    localparam logic [3:0] ST_CHECK = 4'd10;

    localparam logic [2:0] OP_P = 3'd0;
    localparam logic [2:0] OP_I = 3'd1;
    localparam logic [2:0] OP_D = 3'd2;
    localparam logic [2:0] OP_N = 3'd3;
    localparam logic [2:0] OP_E = 3'd4;

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        {{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN =
        {{(SUM_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    // control and state
    logic [3:0]        r_state;
    logic [2:0]        r_op;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;
    t_gain             r_gain_p;
    t_gain             r_gain_i;
    t_gain             r_gain_d;
    t_gain             r_limit;
    logic [ERR_W-1:0]  r_prev;
    logic [INT_W-1:0]  r_integral;

    // datapath
    logic [ERR_W-1:0]     r_err;
    t_dt                  r_dt;
    logic                 r_en;
    t_sample              r_tb;
    logic                 r_err_neg;
    logic [ERR_MAG_W-1:0] r_err_mag;
    logic                 r_int_neg;
    logic [INT_W-1:0]     r_int_mag;
    logic [DERR_W-1:0]    r_derr;
    logic                 r_derr_neg;
    logic [DMAG_W-1:0]    r_derr_mag;
    logic [MUL2_W-1:0]    r_prod;
    logic [MUL2_W-1:0]    r_lo;
    logic [TP_W-1:0]      r_tp_mag;
    logic [TI_W-1:0]      r_ti_mag;
    logic [PD_W-1:0]      r_pd;
    logic [TD_W-1:0]      r_td_mag;
    logic [INC_W-1:0]     r_inc_mag;
    logic [DVD_W-1:0]     r_dvd;
    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      r_dvs;
    logic [SUM_W-1:0]     r_sum;
    logic [SAMPLE_W-1:0]  r_drive;
    logic [CAND_W-1:0]    r_cand;
    logic                 r_thr_ok;
    logic [SAMPLE_W-1:0]  r_out_drive;
    logic                 r_out_taken;

    // combinational
    logic [MUL_W-1:0]  mul_a;
    logic [MUL2_W-1:0] mul_b;
    logic [MUL_W-1:0]  mul_chunk;
    logic [ACC_W-1:0]  mac_sum;
    logic [DT_W-1:0]   d_rem;
    logic [DVD_W-1:0]  d_dvd;
    logic [DT_W:0]     d_trial;
    logic [SUM_W-1:0]  tp_term;
    logic [SUM_W-1:0]  ti_term;
    logic [SUM_W-1:0]  td_term;
    logic [SUM_W-1:0]  clamp_in;
    logic [CAND_W-1:0] inc_term;
    logic [CAND_W-1:0] int_ext;
    logic [CAND_W-1:0] limq;
    logic [DRV_W-1:0]  drive_ext;
    logic [DRV_W-1:0]  abs_drive;
    logic [DRV_W-1:0]  lim_ext;
    logic              cand_ok;
    logic              drive_ok;
    logic              take;
    logic              out_free;

    assign i_in.ready           = (r_state == ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_out_valid;
    assign o_out.drive          = r_out_drive;
    assign o_out.integral_taken = r_out_taken;

    assign out_free = !r_out_valid || o_out.ready;

    // operand select of the shared multiplier
    always_comb begin
        unique case (r_op)
            OP_P: begin
                mul_a = MUL_W'(r_gain_p);
                mul_b = MUL2_W'(r_err_mag);
            end
            OP_I: begin
                mul_a = MUL_W'(r_gain_i);
                mul_b = MUL2_W'(r_int_mag);
            end
            OP_D: begin
                mul_a = MUL_W'(r_gain_d);
                mul_b = MUL2_W'(r_derr_mag);
            end
            OP_N: begin
                mul_a = MUL_W'(US_PER_S);
                mul_b = MUL2_W'(r_pd);
            end
            OP_E: begin
                mul_a = MUL_W'(r_dt);
                mul_b = MUL2_W'(r_err_mag);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_chunk = (r_state == ST_MHI) ? mul_b[MUL2_W-1:MUL_W] : mul_b[MUL_W-1:0];
    assign mac_sum   = ACC_W'(r_lo) + {r_prod, {MUL_W{1'b0}}};

    // restoring division, a few quotient bits per cycle shifted into the dividend
    always_comb begin
        d_rem   = r_rem;
        d_dvd   = r_dvd;
        d_trial = '0;
        for (int j = 0; j < DIV_RADIX; j++) begin
            d_trial = {d_rem, d_dvd[DVD_W-1]};
            d_dvd   = {d_dvd[DVD_W-2:0], 1'b0};
            if (d_trial >= {1'b0, r_dvs}) begin
                d_rem    = DT_W'(d_trial - {1'b0, r_dvs});
                d_dvd[0] = 1'b1;
            end else begin
                d_rem = d_trial[DT_W-1:0];
            end
        end
    end

    // signed terms of the drive sum
    assign tp_term  = r_err_neg  ? -SUM_W'(r_tp_mag) : SUM_W'(r_tp_mag);
    assign ti_term  = r_int_neg  ? -SUM_W'(r_ti_mag) : SUM_W'(r_ti_mag);
    assign td_term  = r_derr_neg ? -SUM_W'(r_td_mag) : SUM_W'(r_td_mag);
    assign clamp_in = r_sum + td_term;

    // integral candidate and acceptance window
    assign inc_term  = r_err_neg ? -CAND_W'(r_inc_mag) : CAND_W'(r_inc_mag);
    assign int_ext   = {{(CAND_W-INT_W){r_integral[INT_W-1]}}, r_integral};
    assign drive_ext = {r_drive[SAMPLE_W-1], r_drive};
    assign abs_drive = r_drive[SAMPLE_W-1] ? -drive_ext : drive_ext;
    assign lim_ext   = DRV_W'(r_limit);
    assign limq      = CAND_W'(r_limit) << FRAC_BITS;

    assign cand_ok  = ($signed(r_cand) > $signed(-limq)) && ($signed(r_cand) < $signed(limq));
    assign drive_ok = ($signed(drive_ext) > $signed(-lim_ext))
                   && ($signed(drive_ext) < $signed(lim_ext));
    assign take     = r_en && r_thr_ok && cand_ok && drive_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_P;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_limit     <= '0;
            r_prev      <= '0;
            r_integral  <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_GAIN_P:    r_gain_p <= i_cfg.data;
                    REG_GAIN_I:    r_gain_i <= i_cfg.data;
                    REG_GAIN_D:    r_gain_d <= i_cfg.data;
                    REG_INT_LIMIT: r_limit  <= i_cfg.data;
                endcase
            end

            // a finished step refills the output register, else a taken word empties it
            if ((r_state == ST_CHECK) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_prev  <= r_err;
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_op    <= OP_P;
                    r_state <= ST_MLO;
                end
                ST_MLO: r_state <= ST_MHI;
                ST_MHI: r_state <= ST_MACC;
                ST_MACC: begin
                    unique case (r_op)
                        OP_P: begin
                            r_op    <= OP_I;
                            r_state <= ST_MLO;
                        end
                        OP_I: begin
                            r_op    <= OP_D;
                            r_state <= ST_MLO;
                        end
                        OP_D: begin
                            r_op    <= OP_N;
                            r_state <= ST_MLO;
                        end
                        OP_N: begin
                            // zero elapsed time leaves the derivative term at zero
                            if (r_dt == '0) begin
                                r_state <= ST_SUM;
                            end else begin
                                r_dcnt  <= DCNT_W'(DIV_STEPS - 1);
                                r_state <= ST_DIV;
                            end
                        end
                        OP_E: begin
                            r_dcnt  <= DCNT_W'(DIV_STEPS - 1);
                            r_state <= ST_DIV;
                        end
                        default: r_state <= ST_IDLE;
                    endcase
                end
                ST_DIV: begin
                    if (r_dcnt == '0) begin
                        r_state <= (r_op == OP_E) ? ST_CAND : ST_SUM;
                    end else begin
                        r_dcnt <= r_dcnt - DCNT_W'(1);
                    end
                end
                ST_SUM: r_state <= ST_CLAMP;
                ST_CLAMP: begin
                    r_op    <= OP_E;
                    r_state <= ST_MLO;
                end
                ST_CAND: r_state <= ST_CHECK;
                ST_CHECK: begin
                    if (out_free) begin
                        if (!r_en) begin
                            r_integral <= '0;
                        end else if (take) begin
                            r_integral <= r_cand[INT_W-1:0];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MUL2_W'(mul_a) * MUL2_W'(mul_chunk);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    r_err <= {i_in.setpoint[SAMPLE_W-1], i_in.setpoint}
                           - {i_in.measured[SAMPLE_W-1], i_in.measured};
                    r_dt  <= i_in.elapsed_us;
                    r_en  <= i_in.integrate_enable;
                    r_tb  <= i_in.thrust_bound;
                end
            end
            ST_LOAD: begin
                r_derr    <= {r_err[ERR_W-1], r_err} - {r_prev[ERR_W-1], r_prev};
                r_err_neg <= r_err[ERR_W-1];
                r_err_mag <= ERR_MAG_W'(r_err[ERR_W-1] ? -r_err : r_err);
                r_int_neg <= r_integral[INT_W-1];
                r_int_mag <= r_integral[INT_W-1] ? -r_integral : r_integral;
            end
            ST_DIFF: begin
                r_derr_neg <= r_derr[DERR_W-1];
                r_derr_mag <= DMAG_W'(r_derr[DERR_W-1] ? -r_derr : r_derr);
            end
            ST_MHI: r_lo <= r_prod;
            ST_MACC: begin
                unique case (r_op)
                    OP_P: r_tp_mag <= mac_sum[FRAC_BITS +: TP_W];
                    OP_I: r_ti_mag <= mac_sum[2*FRAC_BITS +: TI_W];
                    OP_D: r_pd     <= mac_sum[PD_W-1:0];
                    OP_N: begin
                        // gain_d * |derr| * 10^6 / 2^frac, then divided by elapsed_us
                        r_dvd    <= DVD_W'(mac_sum >> FRAC_BITS);
                        r_dvs    <= r_dt;
                        r_rem    <= '0;
                        r_td_mag <= '0;
                    end
                    OP_E: begin
                        // |err| * elapsed_us * 2^frac, then divided by 10^6
                        r_dvd <= DVD_W'(mac_sum << FRAC_BITS);
                        r_dvs <= US_PER_S;
                        r_rem <= '0;
                    end
                    default: ;
                endcase
            end
            ST_DIV: begin
                r_rem <= d_rem;
                r_dvd <= d_dvd;
                if (r_dcnt == '0) begin
                    if (r_op == OP_E) begin
                        r_inc_mag <= d_dvd[INC_W-1:0];
                    end else begin
                        r_td_mag <= (d_dvd >= DVD_W'(TERM_CAP)) ? TERM_CAP : d_dvd[TD_W-1:0];
                    end
                end
            end
            ST_SUM: r_sum <= tp_term + ti_term;
            ST_CLAMP: begin
                priority if ($signed(clamp_in) > SUM_MAX) begin
                    r_drive <= SUM_MAX[SAMPLE_W-1:0];
                end else if ($signed(clamp_in) < SUM_MIN) begin
                    r_drive <= SUM_MIN[SAMPLE_W-1:0];
                end else begin
                    r_drive <= clamp_in[SAMPLE_W-1:0];
                end
            end
            ST_CAND: begin
                r_cand   <= int_ext + inc_term;
                r_thr_ok <= $signed({1'b0, abs_drive}) < $signed({{2{r_tb[SAMPLE_W-1]}}, r_tb});
            end
            ST_CHECK: begin
                if (out_free) begin
                    r_out_drive <= r_drive;
                    r_out_taken <= take;
                end
            end
            default: ;
        endcase
    end

endmodule
